[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for concurrent checks, clocked on the rising edge and
// disabled while the active-low reset is held
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[hw/rtl/pgf_pkg.sv]
// ----------------------------------------------------------------------------
// pgf_pkg
// Shared widths, register indexes and types of the potential gradient field
// ----------------------------------------------------------------------------
package pgf_pkg;

  // field widths
  localparam int COORD_W = 12;
  localparam int POT_W   = 16;
  localparam int COMP_W  = 17;
  localparam int MAG_W   = 16;
  localparam int SQ_W    = 32;
  localparam int RAD_W   = 34;
  localparam int ROOT_W  = RAD_W / 2;
  localparam int REM_W   = ROOT_W + 1;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 2'd1;

  // grid size limit, clamped at write time
  localparam int DIM_W     = 17;
  localparam int MAX_DIM   = 4096;
  localparam int DIM_RESET = 4096;
  localparam logic [DIM_W-1:0] LIM_RESET =
    DIM_W'((DIM_RESET > MAX_DIM) ? MAX_DIM : DIM_RESET);

  // pipeline depth: diff, square, sum, one per root bit, output
  localparam int NS = 3 + ROOT_W + 1;

  typedef struct packed {
    logic [COORD_W-1:0]      col;
    logic [COORD_W-1:0]      row;
    logic signed [POT_W-1:0] v_center;
    logic signed [POT_W-1:0] v_left;
    logic signed [POT_W-1:0] v_right;
    logic signed [POT_W-1:0] v_up;
    logic signed [POT_W-1:0] v_down;
    logic                    is_conductor;
    logic                    mtl_left;
    logic                    mtl_right;
    logic                    mtl_above;
    logic                    mtl_below;
  } cell_t;

  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
  } dims_t;

endpackage

[hw/rtl/pgf_in_if.sv]
// ----------------------------------------------------------------------------
// pgf_in_if
// Cell channel: valid/ready handshake with one grid cell per transfer
// ----------------------------------------------------------------------------
interface pgf_in_if;
  import pgf_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [COORD_W-1:0]      col;
  logic [COORD_W-1:0]      row;
  logic signed [POT_W-1:0] v_center;
  logic signed [POT_W-1:0] v_left;
  logic signed [POT_W-1:0] v_right;
  logic signed [POT_W-1:0] v_up;
  logic signed [POT_W-1:0] v_down;
  logic                    is_conductor;
  logic                    mtl_left;
  logic                    mtl_right;
  logic                    mtl_above;
  logic                    mtl_below;

  modport source (
    output valid, col, row, v_center, v_left, v_right, v_up, v_down,
           is_conductor, mtl_left, mtl_right, mtl_above, mtl_below,
    input  ready
  );

  modport sink (
    input  valid, col, row, v_center, v_left, v_right, v_up, v_down,
           is_conductor, mtl_left, mtl_right, mtl_above, mtl_below,
    output ready
  );
endinterface

[hw/rtl/pgf_out_if.sv]
// ----------------------------------------------------------------------------
// pgf_out_if
// Field channel: valid/ready handshake with one field result per transfer
// ----------------------------------------------------------------------------
interface pgf_out_if;
  import pgf_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [COMP_W-1:0] field_x;
  logic signed [COMP_W-1:0] field_y;
  logic [MAG_W-1:0]         field_mag;

  modport source (
    output valid, field_x, field_y, field_mag,
    input  ready
  );

  modport sink (
    input  valid, field_x, field_y, field_mag,
    output ready
  );
endinterface

[hw/rtl/potential_gradient_field.sv]
// ----------------------------------------------------------------------------
// potential_gradient_field
// Finite-difference electric field per grid cell: Ex, Ey and floor magnitude
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  --------+-----------+-------------------------------------------------
//  in_ch   | sink      | col, row, five potentials, conductor, metal flags
//  out_ch  | source    | field_x, field_y, field_mag
//  cfg_*   | write     | grid_width (index 0), grid_height (index 1)
//
// One cell per cycle while the output is accepted; 21 register stages:
// difference, square, sum, 17 root-bit stages and the output register.
// Each stage holds its own valid bit and loads whenever it is empty or the
// stage after it moves, so bubbles close up and a stalled output only holds
// the input once every stage is full. Reset clears the valid bits and sets
// both grid sizes to 4096.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module potential_gradient_field (
  input  logic                             clk,
  input  logic                             rst_n,
  pgf_in_if.sink                           in_ch,
  pgf_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [pgf_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [pgf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import pgf_pkg::*;

  logic [DIM_W-1:0]         gw_lim_r;
  logic [DIM_W-1:0]         gh_lim_r;
  logic [DIM_W-1:0]         lim_nxt;
  dims_t                    lim;
  cell_t                    pt;
  logic [NS:0]              en;
  logic [NS-1:0]            v_r;
  logic signed [COMP_W-1:0] ex_d;
  logic signed [COMP_W-1:0] ey_d;
  logic [RAD_W-1:0]         sum_s;
  logic signed [COMP_W-1:0] ex_s;
  logic signed [COMP_W-1:0] ey_s;
  logic [ROOT_W-1:0]        root;
  logic signed [COMP_W-1:0] ex_q;
  logic signed [COMP_W-1:0] ey_q;
  logic signed [COMP_W-1:0] fx_r;
  logic signed [COMP_W-1:0] fy_r;
  logic [MAG_W-1:0]         mag_r;
  logic [MAG_W-1:0]         mag_nxt;

  // grid size registers, clamped to the largest supported grid
  assign lim_nxt = (DIM_W'(cfg_data) > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM)
                                                         : DIM_W'(cfg_data);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_lim_r <= LIM_RESET;
      gh_lim_r <= LIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_GRID_WIDTH:  gw_lim_r <= lim_nxt;
        REG_GRID_HEIGHT: gh_lim_r <= lim_nxt;
        default: ;
      endcase
    end
  end

  assign lim.width  = gw_lim_r;
  assign lim.height = gh_lim_r;

  // stage enables: a stage loads when empty or when its successor moves
  always_comb begin
    en[NS] = out_ch.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) v_r[0] <= in_ch.valid;
      for (int k = 1; k < NS; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  assign in_ch.ready = en[0];

  // cell fields from the input channel
  assign pt.col          = in_ch.col;
  assign pt.row          = in_ch.row;
  assign pt.v_center     = in_ch.v_center;
  assign pt.v_left       = in_ch.v_left;
  assign pt.v_right      = in_ch.v_right;
  assign pt.v_up         = in_ch.v_up;
  assign pt.v_down       = in_ch.v_down;
  assign pt.is_conductor = in_ch.is_conductor;
  assign pt.mtl_left     = in_ch.mtl_left;
  assign pt.mtl_right    = in_ch.mtl_right;
  assign pt.mtl_above    = in_ch.mtl_above;
  assign pt.mtl_below    = in_ch.mtl_below;

  // difference stage
  pgf_diff u_diff (
    .clk  (clk),
    .en   (en[0]),
    .pt   (pt),
    .lim  (lim),
    .ex_r (ex_d),
    .ey_r (ey_d)
  );

  // square and sum stages
  pgf_square u_square (
    .clk   (clk),
    .en    (en[2:1]),
    .ex    (ex_d),
    .ey    (ey_d),
    .sum_r (sum_s),
    .ex2_r (ex_s),
    .ey2_r (ey_s)
  );

  // root stages
  pgf_sqrt u_sqrt (
    .clk  (clk),
    .en   (en[3 +: ROOT_W]),
    .rad  (sum_s),
    .ex   (ex_s),
    .ey   (ey_s),
    .root (root),
    .ex_o (ex_q),
    .ey_o (ey_q)
  );

  // output register with magnitude saturation
  assign mag_nxt = root[ROOT_W-1] ? {MAG_W{1'b1}} : root[MAG_W-1:0];

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      fx_r  <= ex_q;
      fy_r  <= ey_q;
      mag_r <= mag_nxt;
    end
  end

  assign out_ch.valid     = v_r[NS-1];
  assign out_ch.field_x   = fx_r;
  assign out_ch.field_y   = fy_r;
  assign out_ch.field_mag = mag_r;

  // input only stalls when every stage is full and the output is held
  `ASSERT_IMPLIES(a_stall_only_full, clk, rst_n, !in_ch.ready, (&v_r) && !out_ch.ready)

  // a taken result with nothing behind it leaves the output empty
  `ASSERT_NEXT(a_drain_empty, clk, rst_n, out_ch.valid && out_ch.ready && !v_r[NS-2], !out_ch.valid)

  // an in-range width write lands unchanged
  `ASSERT_NEXT(a_width_write, clk, rst_n, cfg_we && (cfg_idx == REG_GRID_WIDTH) && (DIM_W'(cfg_data) <= DIM_W'(MAX_DIM)), gw_lim_r == DIM_W'($past(cfg_data)))
endmodule

[hw/rtl/pgf_diff.sv]
// ----------------------------------------------------------------------------
// pgf_diff
// First stage: interior test and finite difference of both components
// ----------------------------------------------------------------------------
module pgf_diff (
  input  logic                              clk,
  input  logic                              en,
  input  pgf_pkg::cell_t                    pt,
  input  pgf_pkg::dims_t                    lim,
  output logic signed [pgf_pkg::COMP_W-1:0] ex_r,
  output logic signed [pgf_pkg::COMP_W-1:0] ey_r
);
  import pgf_pkg::*;

  logic                     in_x;
  logic                     in_y;
  logic signed [COMP_W-1:0] vc;
  logic signed [COMP_W-1:0] vl;
  logic signed [COMP_W-1:0] vr;
  logic signed [COMP_W-1:0] vu;
  logic signed [COMP_W-1:0] vd;
  logic signed [COMP_W-1:0] hx;
  logic signed [COMP_W-1:0] hy;
  logic signed [COMP_W-1:0] ex_nxt;
  logic signed [COMP_W-1:0] ey_nxt;

  // interior column and row: 0 < pos < lim - 1
  assign in_x = !pt.is_conductor && (pt.col != '0) &&
                ((DIM_W'(pt.col) + DIM_W'(1)) < lim.width);
  assign in_y = !pt.is_conductor && (pt.row != '0) &&
                ((DIM_W'(pt.row) + DIM_W'(1)) < lim.height);

  // sign-extend potentials so every difference fits
  assign vc = COMP_W'(pt.v_center);
  assign vl = COMP_W'(pt.v_left);
  assign vr = COMP_W'(pt.v_right);
  assign vu = COMP_W'(pt.v_up);
  assign vd = COMP_W'(pt.v_down);

  // central difference halved by arithmetic shift
  assign hx = (vl - vr) >>> 1;
  assign hy = (vd - vu) >>> 1;

  // one-sided difference next to metal, metal right / below first
  always_comb begin
    ex_nxt = '0;
    ey_nxt = '0;
    if (in_x) begin
      priority if (pt.mtl_right) ex_nxt = vl - vc;
      else if (pt.mtl_left)      ex_nxt = vc - vr;
      else                       ex_nxt = hx;
    end
    if (in_y) begin
      priority if (pt.mtl_below) ey_nxt = vc - vu;
      else if (pt.mtl_above)     ey_nxt = vd - vc;
      else                       ey_nxt = hy;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ex_r <= ex_nxt;
      ey_r <= ey_nxt;
    end
  end
endmodule

[hw/rtl/pgf_square.sv]
// ----------------------------------------------------------------------------
// pgf_square
// Two stages: square of each component, then the sum of squares
// ----------------------------------------------------------------------------
module pgf_square (
  input  logic                              clk,
  input  logic [1:0]                        en,
  input  logic signed [pgf_pkg::COMP_W-1:0] ex,
  input  logic signed [pgf_pkg::COMP_W-1:0] ey,
  output logic [pgf_pkg::RAD_W-1:0]         sum_r,
  output logic signed [pgf_pkg::COMP_W-1:0] ex2_r,
  output logic signed [pgf_pkg::COMP_W-1:0] ey2_r
);
  import pgf_pkg::*;

  logic signed [2*COMP_W-1:0] sqx_full;
  logic signed [2*COMP_W-1:0] sqy_full;
  logic [SQ_W-1:0]            sqx_r;
  logic [SQ_W-1:0]            sqy_r;
  logic signed [COMP_W-1:0]   ex1_r;
  logic signed [COMP_W-1:0]   ey1_r;
  logic [RAD_W-1:0]           sum_nxt;

  // squares stay below 2^32 for any 17-bit difference of 16-bit inputs
  assign sqx_full = ex * ex;
  assign sqy_full = ey * ey;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      sqx_r <= sqx_full[SQ_W-1:0];
      sqy_r <= sqy_full[SQ_W-1:0];
      ex1_r <= ex;
      ey1_r <= ey;
    end
  end

  // sum of squares
  assign sum_nxt = RAD_W'(sqx_r) + RAD_W'(sqy_r);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sum_r <= sum_nxt;
      ex2_r <= ex1_r;
      ey2_r <= ey1_r;
    end
  end
endmodule

[hw/rtl/pgf_sqrt.sv]
// ----------------------------------------------------------------------------
// pgf_sqrt
// Pipelined restoring square root, one result bit per stage
// ----------------------------------------------------------------------------
module pgf_sqrt (
  input  logic                              clk,
  input  logic [pgf_pkg::ROOT_W-1:0]        en,
  input  logic [pgf_pkg::RAD_W-1:0]         rad,
  input  logic signed [pgf_pkg::COMP_W-1:0] ex,
  input  logic signed [pgf_pkg::COMP_W-1:0] ey,
  output logic [pgf_pkg::ROOT_W-1:0]        root,
  output logic signed [pgf_pkg::COMP_W-1:0] ex_o,
  output logic signed [pgf_pkg::COMP_W-1:0] ey_o
);
  import pgf_pkg::*;

  logic [RAD_W-1:0]         rad_r  [ROOT_W];
  logic [REM_W-1:0]         rem_r  [ROOT_W];
  logic [ROOT_W-1:0]        root_r [ROOT_W];
  logic signed [COMP_W-1:0] ex_r   [ROOT_W];
  logic signed [COMP_W-1:0] ey_r   [ROOT_W];

  for (genvar j = 0; j < ROOT_W; j++) begin : g_bit
    logic [RAD_W-1:0]         rad_in;
    logic [REM_W-1:0]         rem_in;
    logic [ROOT_W-1:0]        root_in;
    logic signed [COMP_W-1:0] ex_in;
    logic signed [COMP_W-1:0] ey_in;
    logic [REM_W+1:0]         rem_sh;
    logic [REM_W+1:0]         trial;
    logic                     take;
    logic [REM_W+1:0]         rem_diff;

    // stage inputs: the sum for the first stage, the previous stage otherwise
    if (j == 0) begin : g_first
      assign rad_in  = rad;
      assign rem_in  = '0;
      assign root_in = '0;
      assign ex_in   = ex;
      assign ey_in   = ey;
    end else begin : g_next
      assign rad_in  = rad_r[j-1];
      assign rem_in  = rem_r[j-1];
      assign root_in = root_r[j-1];
      assign ex_in   = ex_r[j-1];
      assign ey_in   = ey_r[j-1];
    end

    // bring down two radicand bits and test against 4*root + 1
    assign rem_sh   = {rem_in, rad_in[RAD_W-1 -: 2]};
    assign trial    = (REM_W+2)'({root_in, 2'b01});
    assign take     = rem_sh >= trial;
    assign rem_diff = rem_sh - trial;

    always_ff @(posedge clk) begin
      if (en[j]) begin
        rad_r[j]  <= {rad_in[RAD_W-3:0], 2'b00};
        rem_r[j]  <= take ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        root_r[j] <= {root_in[ROOT_W-2:0], take};
        ex_r[j]   <= ex_in;
        ey_r[j]   <= ey_in;
      end
    end
  end

  assign root = root_r[ROOT_W-1];
  assign ex_o = ex_r[ROOT_W-1];
  assign ey_o = ey_r[ROOT_W-1];
endmodule
